[src/limit_switch_door_controller_unit_defines.svh]
// ----------------------------------------------------------------------------
// Door controller assertion macros
// Shared concurrent assertion shorthands for the door controller checkers.
// ----------------------------------------------------------------------------
`ifndef LIMIT_SWITCH_DOOR_CONTROLLER_UNIT_DEFINES_SVH
`define LIMIT_SWITCH_DOOR_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LSDC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LSDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lsdc_pkg.sv]
// ----------------------------------------------------------------------------
// Door controller package
// Types, codes and helpers shared by the door controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lsdc_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int TIMEOUT_BITS   = 24;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 24'd30000;

  // Request kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_OPEN  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  // Door state codes as shown on the result channel.
  localparam logic [1:0] DOOR_OPENING = 2'd0;
  localparam logic [1:0] DOOR_CLOSING = 2'd1;
  localparam logic [1:0] DOOR_STANDBY = 2'd2;
  localparam logic [1:0] DOOR_ERROR   = 2'd3;

  typedef enum logic [3:0] {
    ST_OPENING = 4'b0001,
    ST_CLOSING = 4'b0010,
    ST_STANDBY = 4'b0100,
    ST_ERROR   = 4'b1000
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       open_switch_n;
    logic       close_switch_n;
  } item_t;

  typedef struct packed {
    logic       motor_on;
    logic       motor_up;
    logic       alarm;
    logic [1:0] door_state;
  } result_t;

  function automatic logic [1:0] state_code(input state_t st);
    logic [1:0] code;
    code = DOOR_ERROR;
    unique case (st)
      ST_OPENING: code = DOOR_OPENING;
      ST_CLOSING: code = DOOR_CLOSING;
      ST_STANDBY: code = DOOR_STANDBY;
      ST_ERROR:   code = DOOR_ERROR;
      default:    code = DOOR_ERROR;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[src/lsdc_in_reg.sv]
// ----------------------------------------------------------------------------
// Door controller input register
// Captures one request and holds it until the state update consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdc_in_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire lsdc_pkg::item_t in_item,
  input  wire logic           take,
  output      logic           item_valid,
  output      lsdc_pkg::item_t item
);
  import lsdc_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // The register is free when empty or when its request moves on this cycle.
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

[src/lsdc_core.sv]
// ----------------------------------------------------------------------------
// Door controller state update
// Holds the door state, tick counter, motor and alarm registers and the
// timeout register, and computes the next values for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdc_core #(
  parameter int COUNT_BITS = lsdc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_write,
  input  wire logic [lsdc_pkg::TIMEOUT_BITS-1:0] cfg_timeout,
  input  wire logic                              take,
  input  wire lsdc_pkg::item_t                   item,
  output      lsdc_pkg::result_t                 result_nxt
);
  import lsdc_pkg::*;

  localparam int CMP_BITS = (COUNT_BITS > TIMEOUT_BITS) ? COUNT_BITS : TIMEOUT_BITS;

  state_t                  state_r, state_nxt;
  logic [COUNT_BITS-1:0]   elapsed_r, elapsed_nxt;
  logic [COUNT_BITS-1:0]   elapsed_inc;
  logic                    motor_on_r, motor_on_nxt;
  logic                    motor_up_r, motor_up_nxt;
  logic                    alarm_r, alarm_nxt;
  logic [TIMEOUT_BITS-1:0] timeout_r;
  logic                    at_open;
  logic                    at_closed;
  logic                    to_open;
  logic                    cmd_reached;
  logic                    move_reached;
  logic                    timed_out;

  assign at_open   = !item.open_switch_n && item.close_switch_n;
  assign at_closed = !item.close_switch_n && item.open_switch_n;
  assign to_open   = (item.kind == KIND_OPEN);
  assign cmd_reached  = to_open ? at_open : at_closed;
  assign move_reached = (state_r == ST_OPENING) ? at_open : at_closed;

  // The counter stops at all ones.
  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + COUNT_BITS'(1);
  assign timed_out   = CMP_BITS'(elapsed_inc) > CMP_BITS'(timeout_r);

  always_comb begin
    state_nxt    = state_r;
    elapsed_nxt  = elapsed_r;
    motor_on_nxt = motor_on_r;
    motor_up_nxt = motor_up_r;
    alarm_nxt    = alarm_r;
    if (item.kind == KIND_OPEN || item.kind == KIND_CLOSE) begin
      elapsed_nxt = '0;
      if (cmd_reached) begin
        state_nxt    = ST_STANDBY;
        alarm_nxt    = 1'b0;
        motor_on_nxt = 1'b0;
      end else begin
        state_nxt    = to_open ? ST_OPENING : ST_CLOSING;
        motor_on_nxt = 1'b1;
        motor_up_nxt = to_open;
      end
    end else begin
      // A tick, and the unused kind is treated the same way.
      elapsed_nxt = elapsed_inc;
      unique case (state_r)
        ST_OPENING, ST_CLOSING: begin
          if (move_reached) begin
            state_nxt    = ST_STANDBY;
            elapsed_nxt  = '0;
            alarm_nxt    = 1'b0;
            motor_on_nxt = 1'b0;
          end else if (timed_out) begin
            state_nxt    = ST_ERROR;
            elapsed_nxt  = '0;
            motor_on_nxt = 1'b0;
          end
        end
        ST_ERROR: begin
          alarm_nxt = 1'b1;
        end
        ST_STANDBY: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_OPENING;
      elapsed_r  <= '0;
      motor_on_r <= 1'b1;
      motor_up_r <= 1'b1;
      alarm_r    <= 1'b0;
    end else if (take) begin
      state_r    <= state_nxt;
      elapsed_r  <= elapsed_nxt;
      motor_on_r <= motor_on_nxt;
      motor_up_r <= motor_up_nxt;
      alarm_r    <= alarm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      timeout_r <= cfg_timeout;
    end
  end

  assign result_nxt.motor_on   = motor_on_nxt;
  assign result_nxt.motor_up   = motor_up_nxt;
  assign result_nxt.alarm      = alarm_nxt;
  assign result_nxt.door_state = state_code(state_nxt);

endmodule

`default_nettype wire

[src/lsdc_out_reg.sv]
// ----------------------------------------------------------------------------
// Door controller result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdc_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire lsdc_pkg::result_t result_nxt,
  output      logic              space,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      lsdc_pkg::result_t result
);
  import lsdc_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  assign space     = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = valid_r;
  assign result    = result_r;

endmodule

`default_nettype wire

[src/limit_switch_door_controller_unit.sv]
// ----------------------------------------------------------------------------
// Limit switch door controller
// Top level: input register, state update and result register.
// ----------------------------------------------------------------------------
// Each request (tick, open or close command with both limit switch levels)
// is taken into an input register. The door state is updated and the result
// register is loaded together when that request moves on, which waits while
// the result register is full and out_ready is low. One request is accepted
// per cycle; in_ready drops only while the result register is full and
// out_ready is low. cfg_ready is always high; the timeout is to be written
// only while no request is in flight.
`default_nettype none

module limit_switch_door_controller_unit #(
  parameter int COUNT_BITS = lsdc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [lsdc_pkg::TIMEOUT_BITS-1:0] cfg_timeout_ticks,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic [1:0]                        in_kind,
  input  wire logic                              in_open_switch_n,
  input  wire logic                              in_close_switch_n,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic                              out_motor_on,
  output      logic                              out_motor_up,
  output      logic                              out_alarm,
  output      logic [1:0]                        out_door_state
);
  import lsdc_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    space;
  logic    take;
  result_t result_nxt;
  result_t result;

  assign cfg_ready = 1'b1;

  assign in_item.kind           = in_kind;
  assign in_item.open_switch_n  = in_open_switch_n;
  assign in_item.close_switch_n = in_close_switch_n;

  assign take = item_valid && space;

  lsdc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  lsdc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_timeout (cfg_timeout_ticks),
    .take        (take),
    .item        (item),
    .result_nxt  (result_nxt)
  );

  lsdc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take),
    .result_nxt (result_nxt),
    .space      (space),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign out_motor_on   = result.motor_on;
  assign out_motor_up   = result.motor_up;
  assign out_alarm      = result.alarm;
  assign out_door_state = result.door_state;

endmodule

`default_nettype wire

[src/lsdc_port_checker.sv]
// ----------------------------------------------------------------------------
// Door controller port checker
// Watches the door controller result channel and checks that a stalled result
// holds and that the motor and alarm lines agree with the reported door state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "limit_switch_door_controller_unit_defines.svh"

module lsdc_port_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_motor_on,
  input wire logic       out_motor_up,
  input wire logic       out_alarm,
  input wire logic [1:0] out_door_state
);
  import lsdc_pkg::*;

  `LSDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({out_motor_on, out_motor_up, out_alarm, out_door_state}), "stalled result changed")
  `LSDC_ASSERT_IMPLY(a_standby_quiet, out_valid && out_door_state == DOOR_STANDBY, !out_motor_on && !out_alarm, "standby with motor or alarm on")
  `LSDC_ASSERT_IMPLY(a_error_stopped, out_valid && out_door_state == DOOR_ERROR, !out_motor_on, "motor running in error")
  `LSDC_ASSERT_IMPLY(a_opening_up, out_valid && out_door_state == DOOR_OPENING, out_motor_on && out_motor_up, "opening without motor up")
  `LSDC_ASSERT_IMPLY(a_closing_down, out_valid && out_door_state == DOOR_CLOSING, out_motor_on && !out_motor_up, "closing without motor down")

endmodule

bind limit_switch_door_controller_unit lsdc_port_checker u_port_checker (.*);

`default_nettype wire
